>>> rtl/lzce_pkg.sv
// shared constants, types and codes of the zero-crossing edge core
package lzce_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_WINDOW = 7;
   localparam int MAX_RADIUS = (MAX_WINDOW - 1) / 2;

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int RAD_W  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;

   localparam int PIXEL_W      = 8;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int WINDOW_REG_W = 3;
   localparam int THRESH_REG_W = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;
   localparam logic [WINDOW_REG_W-1:0] WINDOW_RESET = 3'd3;
   localparam logic [THRESH_REG_W-1:0] THRESH_RESET = 7'd0;

   localparam logic             CMD_PIXEL = 1'b0;
   localparam logic             CMD_FLUSH = 1'b1;
   localparam logic [PIXEL_W:0] MID_LEVEL = 9'd128;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [COL_W-1:0]   col_type;

   localparam pixel_type PIXEL_MAX = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2,
      CSR_THRESHOLD    = 2'd3
   } csr_index_type;

   // one window column travelling down the cell chain
   typedef struct packed {
      logic      valid;
      logic      last;
      logic      center;
      col_type   column;
      pixel_type lo;
      pixel_type hi;
      pixel_type ctr;
   } link_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic      wr_en;
      col_type   wr_col;
      pixel_type wr_data;
      logic      row_incl;
      logic      center_row;
   } cell_cmd_type;

endpackage

>>> rtl/lzce_if.sv
// request and response channel interfaces of the zero-crossing edge core
interface lzce_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   lzce_pkg::pixel_type log_pixel;

   modport source (output valid, output command, output log_pixel, input ready);
   modport sink (input valid, input command, input log_pixel, output ready);
endinterface

interface lzce_rsp_if;
   logic                valid;
   logic                ready;
   lzce_pkg::pixel_type edge_value;
   logic                frame_end;

   modport source (output valid, output edge_value, output frame_end, input ready);
   modport sink (input valid, input edge_value, input frame_end, output ready);
endinterface

>>> rtl/lzce_cell.sv
// one line-store row cell: row memory plus min, max and center stage of the chain
module lzce_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lzce_pkg::cell_cmd_type cmd,
   input  lzce_pkg::link_type     link_in,
   output lzce_pkg::link_type     link_out
);

   lzce_pkg::pixel_type line_mem [lzce_pkg::MAX_WIDTH];
   lzce_pkg::pixel_type rd_data_ff;
   lzce_pkg::link_type  hold_ff;
   logic                hold_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         line_mem[cmd.wr_col] <= cmd.wr_data;
      end
      rd_data_ff <= line_mem[link_in.column];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= link_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= link_in;
   end

   always_comb begin
      link_out       = hold_ff;
      link_out.valid = hold_valid_ff;
      if (cmd.row_incl) begin
         if (rd_data_ff < hold_ff.lo) begin
            link_out.lo = rd_data_ff;
         end
         if (rd_data_ff > hold_ff.hi) begin
            link_out.hi = rd_data_ff;
         end
      end
      if (cmd.center_row && hold_ff.center) begin
         link_out.ctr = rd_data_ff;
      end
   end

endmodule

>>> rtl/lzce_ctrl.sv
// sequencer: registers, positions, window sweep, accumulation and response register
module lzce_ctrl (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [lzce_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [lzce_pkg::CSR_DATA_W-1:0]           csr_write_data,
   lzce_req_if.sink                                  req_chan,
   lzce_rsp_if.source                                rsp_chan,
   output lzce_pkg::cell_cmd_type [lzce_pkg::MAX_WINDOW-1:0] cell_cmd,
   output lzce_pkg::link_type                        head_link,
   input  lzce_pkg::link_type                        tail_link
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_SETTLE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   localparam int COL_W  = lzce_pkg::COL_W;
   localparam int ROW_W  = lzce_pkg::ROW_W;
   localparam int SLOT_W = lzce_pkg::SLOT_W;
   localparam int RAD_W  = lzce_pkg::RAD_W;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (int'(s) >= lzce_pkg::MAX_WINDOW - 1) begin
         n = '0;
      end else begin
         n = s + 1'b1;
      end
      return n;
   endfunction

   logic [lzce_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [lzce_pkg::HEIGHT_REG_W-1:0] image_height_ff;
   logic [lzce_pkg::WINDOW_REG_W-1:0] window_size_ff;
   logic [lzce_pkg::THRESH_REG_W-1:0] threshold_ff;

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]    in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0]   in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic                draining_ff, draining_in;
   logic [COL_W-1:0]    sweep_col_ff, sweep_col_in;
   lzce_pkg::pixel_type acc_lo_ff, acc_lo_in, acc_hi_ff, acc_hi_in, acc_ctr_ff, acc_ctr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   lzce_pkg::pixel_type edge_value_ff, edge_value_in;
   logic                frame_end_ff, frame_end_in;

   logic [COL_W:0]      width_eff;
   logic [ROW_W:0]      height_eff;
   logic [COL_W-1:0]    col_last, col_room, col_lo, col_hi;
   logic [ROW_W-1:0]    row_last, row_room, need_row;
   logic [RAD_W-1:0]    radius, rows_above, rows_below, cols_left, cols_right;
   logic [RAD_W:0]      span;
   logic [SLOT_W-1:0]   top_slot, slot_gap;
   logic                complete, rsp_load, frame_last, lo_ok, hi_ok;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= lzce_pkg::WIDTH_RESET;
         image_height_ff <= lzce_pkg::HEIGHT_RESET;
         window_size_ff  <= lzce_pkg::WINDOW_RESET;
         threshold_ff    <= lzce_pkg::THRESH_RESET;
      end else if (csr_write_enable) begin
         unique case (lzce_pkg::csr_index_type'(csr_index))
            lzce_pkg::CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_write_data[lzce_pkg::WIDTH_REG_W-1:0];
            end
            lzce_pkg::CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_write_data[lzce_pkg::HEIGHT_REG_W-1:0];
            end
            lzce_pkg::CSR_WINDOW_SIZE: begin
               window_size_ff <= csr_write_data[lzce_pkg::WINDOW_REG_W-1:0];
            end
            lzce_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_write_data[lzce_pkg::THRESH_REG_W-1:0];
            end
         endcase
      end
   end

   // clamped frame geometry
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = (COL_W+1)'(1);
      end else if (int'(image_width_ff) > lzce_pkg::MAX_WIDTH) begin
         width_eff = (COL_W+1)'(lzce_pkg::MAX_WIDTH);
      end else begin
         width_eff = (COL_W+1)'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_eff = (ROW_W+1)'(1);
      end else if (int'(image_height_ff) > lzce_pkg::MAX_HEIGHT) begin
         height_eff = (ROW_W+1)'(lzce_pkg::MAX_HEIGHT);
      end else begin
         height_eff = (ROW_W+1)'(image_height_ff);
      end
      if (int'(window_size_ff >> 1) > lzce_pkg::MAX_RADIUS) begin
         radius = RAD_W'(lzce_pkg::MAX_RADIUS);
      end else begin
         radius = RAD_W'(window_size_ff >> 1);
      end
      col_last = COL_W'(width_eff - 1'b1);
      row_last = ROW_W'(height_eff - 1'b1);
   end

   // window bounds around the next result position
   always_comb begin
      row_room   = row_last - out_row_ff;
      col_room   = col_last - out_col_ff;
      rows_above = (out_row_ff < ROW_W'(radius)) ? RAD_W'(out_row_ff) : radius;
      rows_below = (row_room < ROW_W'(radius)) ? RAD_W'(row_room) : radius;
      cols_left  = (out_col_ff < COL_W'(radius)) ? RAD_W'(out_col_ff) : radius;
      cols_right = (col_room < COL_W'(radius)) ? RAD_W'(col_room) : radius;
      col_lo     = out_col_ff - COL_W'(cols_left);
      col_hi     = out_col_ff + COL_W'(cols_right);
      need_row   = out_row_ff + ROW_W'(rows_below);
      span       = (RAD_W+1)'(rows_above) + (RAD_W+1)'(rows_below);
      complete   = (need_row < in_row_ff) || ((need_row == in_row_ff) && (col_hi < in_col_ff));
      if (out_slot_ff >= SLOT_W'(rows_above)) begin
         top_slot = out_slot_ff - SLOT_W'(rows_above);
      end else begin
         top_slot = out_slot_ff + SLOT_W'(lzce_pkg::MAX_WINDOW) - SLOT_W'(rows_above);
      end
   end

   // per-cell commands
   always_comb begin
      slot_gap = '0;
      for (int k = 0; k < lzce_pkg::MAX_WINDOW; k++) begin
         if (SLOT_W'(k) >= top_slot) begin
            slot_gap = SLOT_W'(k) - top_slot;
         end else begin
            slot_gap = SLOT_W'(k) + SLOT_W'(lzce_pkg::MAX_WINDOW) - top_slot;
         end
         cell_cmd[k].row_incl   = ((RAD_W+1)'(slot_gap) <= span)
                                  && (int'(slot_gap) <= int'(span));
         cell_cmd[k].center_row = (out_slot_ff == SLOT_W'(k));
         cell_cmd[k].wr_en      = (state_ff == ST_IDLE) && req_chan.valid
                                  && (req_chan.command == lzce_pkg::CMD_PIXEL)
                                  && !draining_ff && (in_slot_ff == SLOT_W'(k));
         cell_cmd[k].wr_col     = in_col_ff;
         cell_cmd[k].wr_data    = req_chan.log_pixel;
      end
   end

   assign lo_ok = {1'b0, acc_lo_ff} < (lzce_pkg::MID_LEVEL - {2'b00, threshold_ff});
   assign hi_ok = {1'b0, acc_hi_ff} > (lzce_pkg::MID_LEVEL + {2'b00, threshold_ff});
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign frame_last = (out_col_ff >= col_last) && (out_row_ff >= row_last);

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.edge_value = edge_value_ff;
   assign rsp_chan.frame_end  = frame_end_ff;

   always_comb begin
      state_in      = state_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      in_slot_in    = in_slot_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      draining_in   = draining_ff;
      sweep_col_in  = sweep_col_ff;
      acc_lo_in     = acc_lo_ff;
      acc_hi_in     = acc_hi_ff;
      acc_ctr_in    = acc_ctr_ff;
      rsp_valid_in  = rsp_valid_ff;
      edge_value_in = edge_value_ff;
      frame_end_in  = frame_end_ff;

      head_link        = '0;
      head_link.lo     = lzce_pkg::PIXEL_MAX;
      head_link.column = sweep_col_ff;
      head_link.center = (sweep_col_ff == out_col_ff);
      head_link.last   = (sweep_col_ff == col_hi);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // fold the column that leaves the chain
      if (tail_link.valid) begin
         if (tail_link.lo < acc_lo_ff) begin
            acc_lo_in = tail_link.lo;
         end
         if (tail_link.hi > acc_hi_ff) begin
            acc_hi_in = tail_link.hi;
         end
         if (tail_link.center) begin
            acc_ctr_in = tail_link.ctr;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CHECK;
               if ((req_chan.command == lzce_pkg::CMD_PIXEL) && !draining_ff) begin
                  if (in_col_ff >= col_last) begin
                     in_col_in = '0;
                     if (in_row_ff >= row_last) begin
                        in_row_in   = '0;
                        in_slot_in  = '0;
                        draining_in = 1'b1;
                     end else begin
                        in_row_in  = in_row_ff + 1'b1;
                        in_slot_in = next_slot(in_slot_ff);
                     end
                  end else begin
                     in_col_in = in_col_ff + 1'b1;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (draining_ff || complete) begin
               state_in     = ST_SWEEP;
               sweep_col_in = col_lo;
               acc_lo_in    = lzce_pkg::PIXEL_MAX;
               acc_hi_in    = '0;
               acc_ctr_in   = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            head_link.valid = 1'b1;
            if (sweep_col_ff == col_hi) begin
               state_in = ST_SETTLE;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         ST_SETTLE: begin
            if (tail_link.valid && tail_link.last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               edge_value_in = (lo_ok && hi_ok) ? acc_ctr_ff : '0;
               frame_end_in  = frame_last;
               state_in      = ST_IDLE;
               if (out_col_ff >= col_last) begin
                  out_col_in = '0;
                  if (out_row_ff >= row_last) begin
                     out_row_in  = '0;
                     out_slot_in = '0;
                     draining_in = 1'b0;
                     in_col_in   = '0;
                     in_row_in   = '0;
                     in_slot_in  = '0;
                  end else begin
                     out_row_in  = out_row_ff + 1'b1;
                     out_slot_in = next_slot(out_slot_ff);
                  end
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         draining_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         draining_ff  <= draining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_col_ff  <= sweep_col_in;
      acc_lo_ff     <= acc_lo_in;
      acc_hi_ff     <= acc_hi_in;
      acc_ctr_ff    <= acc_ctr_in;
      edge_value_ff <= edge_value_in;
      frame_end_ff  <= frame_end_in;
   end

`ifndef SYNTHESIS
   slot_range_a: assert property (@(posedge clock) disable iff (reset)
      (int'(in_slot_ff) < lzce_pkg::MAX_WINDOW) && (int'(out_slot_ff) < lzce_pkg::MAX_WINDOW))
      else $error("row slot out of range");

   drain_pos_a: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> ((in_col_ff == '0) && (in_row_ff == '0)))
      else $error("input position moved while draining");

   rsp_from_emit_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response loaded outside emit");

   frame_wrap_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && frame_last) |=> ((out_col_ff == '0) && (out_row_ff == '0) && !draining_ff))
      else $error("frame end did not rewind output position");

   sweep_bound_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> ((sweep_col_ff >= col_lo) && (sweep_col_ff <= col_hi)))
      else $error("sweep column outside window");
`endif

endmodule

>>> rtl/log_zero_crossing_edge_core.sv
// top level of the zero-crossing edge core: sequencer and chain of row cells
//
//   channel   dir   handshake          payload
//   req_chan  in    valid / ready      command, log_pixel
//   rsp_chan  out   valid / ready      edge_value, frame_end
//   csr_*     in    write enable only  csr_index, csr_write_data
//
// one request at a time: a request whose window is not yet complete gets no response,
// one that completes a window sweeps its columns inside the frame (1 to 7) first
// the column sweep feeds the seven-cell min/max chain one column per cycle
// synchronous active-high reset; the line store is not cleared
// the response register lets the next request in while a response waits
module log_zero_crossing_edge_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lzce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lzce_pkg::CSR_DATA_W-1:0]  csr_write_data,
   lzce_req_if.sink                         req_chan,
   lzce_rsp_if.source                       rsp_chan
);

   lzce_pkg::cell_cmd_type [lzce_pkg::MAX_WINDOW-1:0] cell_cmd;
   lzce_pkg::link_type                                links [lzce_pkg::MAX_WINDOW+1];

   lzce_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .cell_cmd         (cell_cmd),
      .head_link        (links[0]),
      .tail_link        (links[lzce_pkg::MAX_WINDOW])
   );

   for (genvar k = 0; k < lzce_pkg::MAX_WINDOW; k++) begin : g_cell
      lzce_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cell_cmd[k]),
         .link_in  (links[k]),
         .link_out (links[k+1])
      );
   end

endmodule
